>>> rtl/bdpd_pkg.sv
// Shared types, codes and constants of the block delta patch decoder.
package bdpd_pkg;

  // Command codes on the input stream
  localparam logic [1:0] CMD_PAYLOAD  = 2'd0;
  localparam logic [1:0] CMD_READ     = 2'd1;
  localparam logic [1:0] CMD_READ_CLR = 2'd2;

  // Status codes on the output stream
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_OBSOLETE = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_READ     = 2'd3;

  // Header field masks
  localparam logic [7:0] MASK_NIB  = 8'h0F;
  localparam logic [7:0] MASK_SIX  = 8'h3F;
  localparam logic [2:0] MASK_FORM = 3'h7;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_EXT1 = 3'd1,
    PH_EXT2 = 3'd2,
    PH_EXT3 = 3'd3,
    PH_EXT4 = 3'd4,
    PH_DATA = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_COMMIT
  } ctrl_e;

  // Request to copy a finished run from the staging buffer to the state memory
  typedef struct packed {
    logic        valid;
    logic [24:0] base;
    logic [8:0]  len;
  } commit_req_t;

  // Result of one payload byte
  typedef struct packed {
    logic [1:0] status;
    logic       done;
  } parse_res_t;

  // Extra header bytes per long form
  function automatic logic [2:0] extra_bytes(input logic [2:0] form);
    logic [2:0] n;
    unique case (form)
      3'd0, 3'd1, 3'd7: n = 3'd1;
      3'd2, 3'd3:       n = 3'd2;
      3'd4, 3'd5:       n = 3'd3;
      default:          n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/bdpd_ram.sv
// Generic simple dual-port RAM with registered read.
module bdpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/bdpd_parser.sv
// Mutation sequencing and run header parser of the patch decoder.
module bdpd_parser import bdpd_pkg::*; #(
  parameter int STATE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic [31:0] seq_i,
  output parse_res_t  res_o,
  output logic        buf_we_o,
  output logic [7:0]  buf_addr_o,
  output logic [7:0]  buf_data_o,
  output commit_req_t commit_o
);

  localparam logic [25:0] Limit = 26'(STATE_BYTES);

  logic [31:0] last_seq_q, last_seq_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [23:0] acc_q, acc_d;
  logic [24:0] wi_q, wi_d;
  logic [8:0]  rlen_q, rlen_d;
  logic [8:0]  rcnt_q, rcnt_d;
  logic        stop_q, stop_d;
  logic        inmut_q, inmut_d;

  // Parse one byte
  always_comb begin
    logic        start;
    logic        do_run;
    logic [23:0] off;
    logic [7:0]  lenm1;
    logic [8:0]  len;
    logic [24:0] wnew;
    logic [2:0]  form;
    logic [7:0]  b1, b2, b3;
    logic [8:0]  rnext;

    last_seq_d = last_seq_q;
    phase_d    = phase_q;
    hdr_d      = hdr_q;
    acc_d      = acc_q;
    wi_d       = wi_q;
    rlen_d     = rlen_q;
    rcnt_d     = rcnt_q;
    stop_d     = stop_q;
    inmut_d    = inmut_q;
    res_o      = '{status: ST_ACCEPTED, done: 1'b0};
    buf_we_o   = 1'b0;
    buf_addr_o = rcnt_q[7:0];
    buf_data_o = byte_i;
    commit_o   = '{valid: 1'b0, base: wi_q, len: rlen_q};
    start      = 1'b0;
    do_run     = 1'b0;
    off        = '0;
    lenm1      = '0;
    len        = '0;
    wnew       = '0;
    form       = hdr_q[3:1] & MASK_FORM;
    b1         = '0;
    b2         = '0;
    b3         = '0;
    rnext      = rcnt_q + 9'd1;

    if (step_i) begin
      if (!inmut_q && (seq_i <= last_seq_q)) begin
        res_o.status = ST_OBSOLETE;
      end else begin
        // Open a new mutation
        if (!inmut_q) begin
          start      = 1'b1;
          last_seq_d = seq_i;
          inmut_d    = 1'b1;
          stop_d     = 1'b0;
          wi_d       = '0;
          phase_d    = PH_HDR;
          rcnt_d     = '0;
        end
        if (stop_d) begin
          res_o.status = ST_IGNORED;
        end else begin
          unique case (phase_d)
            PH_EXT1, PH_EXT2, PH_EXT3, PH_EXT4: begin
              if (phase_d == PH_EXT1) acc_d[7:0]   = byte_i;
              if (phase_d == PH_EXT2) acc_d[15:8]  = byte_i;
              if (phase_d == PH_EXT3) acc_d[23:16] = byte_i;
              b1 = acc_d[7:0];
              b2 = acc_d[15:8];
              b3 = acc_d[23:16];
              if (3'(phase_d) >= extra_bytes(form)) begin
                do_run = 1'b1;
                unique case (form)
                  3'd0: begin off = 24'(b1 & MASK_NIB); lenm1 = {4'd0, b1[7:4]}; end
                  3'd1: begin off = 24'(b1 & MASK_SIX); lenm1 = {6'd0, b1[7:6]}; end
                  3'd2: begin off = 24'(b1); lenm1 = b2; end
                  3'd3: begin off = {12'd0, b2[3:0], b1}; lenm1 = {4'd0, b2[7:4]}; end
                  3'd4: begin off = {8'd0, b2, b1}; lenm1 = b3; end
                  3'd5: begin off = {4'd0, b3[3:0], b2, b1}; lenm1 = {4'd0, b3[7:4]}; end
                  3'd6: begin off = {b3, b2, b1}; lenm1 = byte_i; end
                  default: begin off = 24'(b1); lenm1 = {4'd0, hdr_q[7:4]}; end
                endcase
              end else begin
                phase_d = phase_e'(3'(phase_d) + 3'd1);
              end
            end
            PH_DATA: begin
              // Stage the byte; hand the run over once complete
              buf_we_o = 1'b1;
              rcnt_d   = rnext;
              if (rnext >= rlen_q) begin
                commit_o.valid = 1'b1;
                commit_o.base  = wi_d;
                wi_d           = wi_d + 25'(rlen_q);
                phase_d        = PH_HDR;
              end
            end
            default: begin
              if (byte_i[0]) begin
                do_run = 1'b1;
                off    = 24'(byte_i[4:1]);
                lenm1  = {5'd0, byte_i[7:5]};
              end else begin
                hdr_d   = byte_i;
                acc_d   = '0;
                phase_d = PH_EXT1;
              end
            end
          endcase
          // Start the run or stop on an out-of-bounds header
          if (do_run) begin
            len  = 9'(lenm1) + 9'd1;
            wnew = wi_d + 25'(off);
            wi_d = wnew;
            if ({1'b0, wnew} + 26'(len) > Limit) begin
              stop_d  = 1'b1;
              phase_d = PH_HDR;
            end else begin
              rlen_d  = len;
              rcnt_d  = '0;
              phase_d = PH_DATA;
            end
          end
        end
        // Close the mutation, dropping any partial run
        if (last_i) begin
          res_o.done = 1'b1;
          inmut_d    = 1'b0;
          phase_d    = PH_HDR;
          rcnt_d     = '0;
        end
      end
    end
    if (start) begin
      buf_addr_o = rcnt_d[7:0];
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '0;
      phase_q    <= PH_HDR;
      hdr_q      <= '0;
      acc_q      <= '0;
      wi_q       <= '0;
      rlen_q     <= '0;
      rcnt_q     <= '0;
      stop_q     <= 1'b0;
      inmut_q    <= 1'b0;
    end else begin
      last_seq_q <= last_seq_d;
      phase_q    <= phase_d;
      hdr_q      <= hdr_d;
      acc_q      <= acc_d;
      wi_q       <= wi_d;
      rlen_q     <= rlen_d;
      rcnt_q     <= rcnt_d;
      stop_q     <= stop_d;
      inmut_q    <= inmut_d;
    end
  end

endmodule

>>> rtl/block_delta_patch_decoder_top.sv
// Top level of the block delta patch decoder: control, state memory and run staging.
// After reset the block sweeps the state memory in S_CLEAR (data zero, dirty set) and
// takes no request in that time. A byte that completes a run sends the block to S_COMMIT,
// where the staged run is copied one byte a cycle through the single write port of the
// state memory. A read passes through S_READ, which takes the byte from the registered
// read of the state memory. One request is handled at a time; its result waits in an
// output register, and the next request is taken only once that register is empty or read.
module block_delta_patch_decoder_top import bdpd_pkg::*; #(
  parameter int STATE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // command[1:0], payload_byte[9:2], mutation_seq[41:10], address[53:42]
  input  logic [55:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[7:0], read_dirty[8]
  output logic [15:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int AW = (STATE_BYTES > 1) ? $clog2(STATE_BYTES) : 1;
  localparam logic [24:0] Bytes = 25'(STATE_BYTES);

  ctrl_e       st_q, st_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [11:0] raddr_q, raddr_d;
  logic        rclr_q, rclr_d;
  logic [24:0] cbase_q, cbase_d;
  logic [8:0]  clen_q, clen_d;
  logic [8:0]  ccnt_q, ccnt_d;
  logic        wvld_q, wvld_d;
  logic [AW-1:0] waddr_q, waddr_d;
  logic        ovld_q, ovld_d;
  logic [8:0]  odat_q, odat_d;
  logic [1:0]  ostat_q, ostat_d;
  logic        odone_q, odone_d;

  logic        acc;
  logic [1:0]  cmd;
  logic        step;
  parse_res_t  pres;
  commit_req_t creq;
  logic        buf_we;
  logic [7:0]  buf_waddr, buf_wdata, buf_rdata;
  logic [7:0]  buf_raddr;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [8:0]  mem_wdata, mem_rdata;
  logic        rd_in_range;

  assign cmd             = s_axis_tdata_i[1:0];
  assign s_axis_tready_o = (st_q == S_IDLE) && (!ovld_q || m_axis_tready_i);
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign step            = acc && (cmd == CMD_PAYLOAD);
  assign rd_in_range     = 25'(raddr_q) < Bytes;

  bdpd_parser #(.STATE_BYTES(STATE_BYTES)) u_parser (
    .clk_i,
    .rst_ni,
    .step_i     (step),
    .byte_i     (s_axis_tdata_i[9:2]),
    .last_i     (s_axis_tlast_i),
    .seq_i      (s_axis_tdata_i[41:10]),
    .res_o      (pres),
    .buf_we_o   (buf_we),
    .buf_addr_o (buf_waddr),
    .buf_data_o (buf_wdata),
    .commit_o   (creq)
  );

  // Staging buffer for one run
  bdpd_ram #(.WIDTH(8), .DEPTH(256)) u_run_buf (
    .clk_i,
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // State memory: dirty mark over data byte
  bdpd_ram #(.WIDTH(9), .DEPTH(STATE_BYTES)) u_state_mem (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Control and next state
  always_comb begin
    logic [24:0] full_addr;
    st_d      = st_q;
    clr_d     = clr_q;
    raddr_d   = raddr_q;
    rclr_d    = rclr_q;
    cbase_d   = cbase_q;
    clen_d    = clen_q;
    ccnt_d    = ccnt_q;
    wvld_d    = 1'b0;
    waddr_d   = waddr_q;
    ovld_d    = ovld_q && !m_axis_tready_i;
    odat_d    = odat_q;
    ostat_d   = ostat_q;
    odone_d   = odone_q;
    mem_we    = 1'b0;
    mem_waddr = waddr_q;
    mem_wdata = {1'b1, buf_rdata};
    full_addr = 25'(s_axis_tdata_i[53:42]);
    mem_raddr = full_addr[AW-1:0];
    buf_raddr = ccnt_q[7:0];

    unique case (st_q)
      S_CLEAR: begin
        // Sweep the state memory to its reset contents
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {1'b1, 8'd0};
        clr_d     = clr_q + AW'(1);
        if (25'(clr_q) == Bytes - 25'd1) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (cmd != CMD_PAYLOAD) begin
            raddr_d = s_axis_tdata_i[53:42];
            rclr_d  = (cmd == CMD_READ_CLR);
            st_d    = S_READ;
          end else begin
            ovld_d  = 1'b1;
            odat_d  = '0;
            ostat_d = pres.status;
            odone_d = pres.done;
            if (creq.valid) begin
              cbase_d = creq.base;
              clen_d  = creq.len;
              ccnt_d  = '0;
              st_d    = S_COMMIT;
            end
          end
        end
      end
      S_READ: begin
        // Return the byte, clear its mark if asked
        ovld_d    = 1'b1;
        odat_d    = rd_in_range ? mem_rdata : 9'd0;
        ostat_d   = ST_READ;
        odone_d   = 1'b0;
        full_addr = 25'(raddr_q);
        mem_waddr = full_addr[AW-1:0];
        mem_wdata = {1'b0, mem_rdata[7:0]};
        mem_we    = rclr_q && rd_in_range;
        st_d      = S_IDLE;
      end
      S_COMMIT: begin
        // Read the buffer one entry ahead of the memory write
        mem_we = wvld_q;
        if (ccnt_q < clen_q) begin
          full_addr = cbase_q + 25'(ccnt_q);
          waddr_d   = full_addr[AW-1:0];
          wvld_d    = 1'b1;
          ccnt_d    = ccnt_q + 9'd1;
        end else if (!wvld_q) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_CLEAR;
      clr_q  <= '0;
      ccnt_q <= '0;
      clen_q <= '0;
      wvld_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      clr_q  <= clr_d;
      ccnt_q <= ccnt_d;
      clen_q <= clen_d;
      wvld_q <= wvld_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_d;
    rclr_q  <= rclr_d;
    cbase_q <= cbase_d;
    waddr_q <= waddr_d;
    odat_q  <= odat_d;
    ostat_q <= ostat_d;
    odone_q <= odone_d;
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {7'd0, odat_q};
  assign m_axis_tuser_o  = ostat_q;
  assign m_axis_tlast_o  = odone_q;

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CLEAR || st_q == S_COMMIT || st_q == S_READ) |-> !s_axis_tready_o)
    else $error("request taken while busy");

  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_COMMIT) |-> (ccnt_q <= clen_q))
    else $error("run copy overran its length");

  a_read_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd != CMD_PAYLOAD) |=> (st_q == S_READ))
    else $error("read request not served");

  a_read_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_READ) |=> (ovld_q && ostat_q == ST_READ))
    else $error("read reply missing");

endmodule

>>> tb/tb_block_delta_patch_decoder_top.sv
// Self-checking testbench of the block delta patch decoder top level.
`timescale 1ns / 100ps

module tb_block_delta_patch_decoder_top;
  import bdpd_pkg::*;

  localparam int          MEM_BYTES    = 4096;
  localparam int          CYCLE_LIMIT  = 1500000;
  localparam int          TAIL_CYCLES  = 300;
  localparam logic [1:0]  CMD_READ_ALT = 2'd3;
  localparam int          EMBEDDED     = 8;
  localparam logic [24:0] INDEX_MASK   = 25'h1FFFFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  pbyte;
    logic        last;
    logic [31:0] seq;
    logic [11:0] addr;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       dirty;
    logic [1:0] status;
    logic       done;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  request_t pending_q[$];
  reply_t   reply_q[$];
  request_t cur_req;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       fail_count = 0;
  int       cycle_count = 0;

  // Decoder image: state memory, dirty marks and parser registers
  logic [7:0]  img_mem[MEM_BYTES];
  logic        img_dirty[MEM_BYTES];
  logic [7:0]  run_buf[256];
  logic [31:0] last_seq;
  phase_e      phase;
  logic [7:0]  hdr;
  logic [23:0] acc;
  logic [24:0] windex;
  logic [8:0]  run_len;
  logic [8:0]  run_cnt;
  logic        stopped;
  logic        in_mut;
  int          extra_count[8] = '{1, 1, 2, 2, 3, 3, 4, 1};

  block_delta_patch_decoder_top u_top (.*);

  always #6 clk_i = ~clk_i;

  // Apply a skip and start a run, or stop on out-of-bounds
  task automatic begin_run(input logic [23:0] off, input logic [8:0] lenm1);
    logic [9:0] len;
    len = lenm1 + 10'd1;
    windex = (windex + 25'(off)) & INDEX_MASK;
    if (32'(windex) + 32'(len) > MEM_BYTES) begin
      stopped = 1'b1;
      phase = PH_HDR;
    end else begin
      run_len = len[8:0];
      if (len == 10'd256) run_len = 9'd256;
      run_cnt = '0;
      phase = PH_DATA;
    end
  endtask

  // Decode a long header once its final byte has come
  task automatic finish_header(input logic [7:0] b);
    logic [7:0] b1, b2, b3;
    b1 = acc[7:0];
    b2 = acc[15:8];
    b3 = acc[23:16];
    case (hdr[3:1])
      3'd0: begin_run(24'(b1[3:0]), 9'(b1[7:4]));
      3'd1: begin_run(24'(b1[5:0]), 9'(b1[7:6]));
      3'd2: begin_run(24'(b1), 9'(b2));
      3'd3: begin_run({12'd0, b2[3:0], b1}, 9'(b2[7:4]));
      3'd4: begin_run({8'd0, b2, b1}, 9'(b3));
      3'd5: begin_run({4'd0, b3[3:0], b2, b1}, 9'(b3[7:4]));
      3'd6: begin_run({b3, b2, b1}, 9'(b));
      default: begin_run(24'(b1), 9'(hdr[7:4]));
    endcase
  endtask

  task automatic parse_payload(input logic [7:0] b);
    int k;
    int addr;
    case (phase)
      PH_HDR: begin
        if (b[0]) begin
          begin_run(24'(b[4:1]), 9'(b[7:5]));
        end else begin
          hdr = b;
          acc = '0;
          phase = PH_EXT1;
        end
      end
      PH_DATA: begin
        run_buf[run_cnt[7:0]] = b;
        run_cnt = run_cnt + 9'd1;
        if (run_cnt >= run_len) begin
          // Commit the staged run
          for (int i = 0; i < int'(run_len); i++) begin
            addr = int'(windex) + i;
            if (addr < MEM_BYTES) begin
              img_mem[addr] = run_buf[i];
              img_dirty[addr] = 1'b1;
            end
          end
          windex = (windex + 25'(run_len)) & INDEX_MASK;
          phase = PH_HDR;
        end
      end
      default: begin
        k = int'(phase);
        if (k <= 3) acc = acc | (24'(b) << (8 * (k - 1)));
        if (k >= extra_count[hdr[3:1]]) finish_header(b);
        else phase = phase_e'(k + 1);
      end
    endcase
  endtask

  // Work out the reply of one accepted request and advance the image
  task automatic predict_reply(input request_t r, output reply_t e);
    e = '0;
    if (r.cmd != CMD_PAYLOAD) begin
      e.data = img_mem[r.addr];
      e.dirty = img_dirty[r.addr];
      if (r.cmd == CMD_READ_CLR) img_dirty[r.addr] = 1'b0;
      e.status = ST_READ;
    end else if (!in_mut && r.seq <= last_seq) begin
      e.status = ST_OBSOLETE;
    end else begin
      if (!in_mut) begin
        last_seq = r.seq;
        in_mut = 1'b1;
        stopped = 1'b0;
        windex = '0;
        phase = PH_HDR;
        run_cnt = '0;
      end
      if (stopped) begin
        e.status = ST_IGNORED;
      end else begin
        e.status = ST_ACCEPTED;
        parse_payload(r.pbyte);
      end
      if (r.last) begin
        e.done = 1'b1;
        in_mut = 1'b0;
        phase = PH_HDR;
        run_cnt = '0;
      end
    end
  endtask

  // Drive requests from the pending queue, predicting each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t e;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_reply(cur_req, e);
        reply_q.insert(reply_q.size(), e);
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_q[0];
          pending_q.delete(0);
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {2'b00, cur_req.addr, cur_req.seq, cur_req.pbyte, cur_req.cmd};
          s_axis_tlast_i <= cur_req.last;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Check each reply against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t e;
    reply_t got;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tdata_o[7:0], m_axis_tdata_o[8], m_axis_tuser_o, m_axis_tlast_o};
        if (reply_q.size() == 0) begin
          $display("%0t: reply expected none actual %h", $time, got);
          fail_count++;
        end else begin
          e = reply_q[0];
          reply_q.delete(0);
          if (got.data !== e.data)
            $display("%0t: read_data expected %h actual %h", $time, e.data, got.data);
          if (got.dirty !== e.dirty)
            $display("%0t: read_dirty expected %b actual %b", $time, e.dirty, got.dirty);
          if (got.status !== e.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
          if (got.done !== e.done)
            $display("%0t: mutation_done expected %b actual %b", $time, e.done, got.done);
          if (got !== e) fail_count++;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_block_delta_patch_decoder_top failed");
      $finish;
    end
  end

  task automatic push_req(input logic [1:0] cmd, input logic [7:0] b, input logic last,
                          input logic [31:0] seq, input logic [11:0] addr);
    request_t r;
    r.cmd = cmd;
    r.pbyte = b;
    r.last = last;
    r.seq = seq;
    r.addr = addr;
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic push_read();
    logic [1:0] cmd;
    logic [11:0] addr;
    case ($urandom_range(2))
      0: cmd = CMD_READ;
      1: cmd = CMD_READ_CLR;
      default: cmd = CMD_READ_ALT;
    endcase
    addr = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(400));
    push_req(cmd, 8'($urandom), 1'($urandom), $urandom, addr);
  endtask

  // Append the header and data of one run to a byte list
  task automatic add_run(inout logic [7:0] mb[$], input int form, input logic [23:0] off,
                         input logic [7:0] lenm1);
    logic [7:0] head;
    head = {4'($urandom), 3'(form), 1'b0};
    case (form)
      0: mb = {mb, head, {lenm1[3:0], off[3:0]}};
      1: mb = {mb, head, {lenm1[1:0], off[5:0]}};
      2: mb = {mb, head, off[7:0], lenm1};
      3: mb = {mb, head, off[7:0], {lenm1[3:0], off[11:8]}};
      4: mb = {mb, head, off[7:0], off[15:8], lenm1};
      5: mb = {mb, head, off[7:0], off[15:8], {lenm1[3:0], off[19:16]}};
      6: mb = {mb, head, off[7:0], off[15:8], off[23:16], lenm1};
      7: mb = {mb, {lenm1[3:0], 3'd7, 1'b0}, off[7:0]};
      default: mb = {mb, {lenm1[2:0], off[3:0], 1'b1}};
    endcase
    // Run data; the length lives in the fields kept above
    case (form)
      0, 3, 5, 7: lenm1 = 8'(lenm1[3:0]);
      1: lenm1 = 8'(lenm1[1:0]);
      EMBEDDED: lenm1 = 8'(lenm1[2:0]);
      default: ;
    endcase
    for (int i = 0; i <= int'(lenm1); i++) mb = {mb, 8'($urandom)};
  endtask

  // Queue one mutation, reads scattered through it
  task automatic push_mutation(input logic [31:0] seq, input int runs, input bit trunc,
                               input bit long_run);
    logic [7:0] mb[$];
    int form;
    logic [23:0] off;
    logic [7:0] lenm1;
    int cut;
    for (int r = 0; r < runs; r++) begin
      form = $urandom_range(EMBEDDED);
      off = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(15));
      lenm1 = (long_run && r == 0) ? 8'd255 : 8'($urandom_range(7));
      if (long_run && r == 0) form = 2;
      add_run(mb, form, off, lenm1);
    end
    if (trunc) begin
      cut = $urandom_range(mb.size() - 1, 1);
      mb = mb[0:cut - 1];
    end
    if ($urandom_range(9) == 0) mb = {mb, 8'($urandom)};
    foreach (mb[i]) begin
      if ($urandom_range(7) == 0) push_read();
      push_req(CMD_PAYLOAD, mb[i], i == mb.size() - 1, seq, 12'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || s_axis_tvalid_i || reply_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] mb[$];
    logic [31:0] seq;
    int pushed;
    int pick;
    foreach (img_mem[i]) begin
      img_mem[i] = '0;
      img_dirty[i] = 1'b1;
    end
    last_seq = '0;
    phase = PH_HDR;
    hdr = '0;
    acc = '0;
    windex = '0;
    run_len = '0;
    run_cnt = '0;
    stopped = 1'b0;
    in_mut = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reads at both ends, clearing read, the spare command
    push_req(CMD_READ, 8'h00, 1'b0, 32'h0, 12'd0);
    push_req(CMD_READ_CLR, 8'hFF, 1'b1, 32'hFFFFFFFF, 12'hFFF);
    push_req(CMD_READ, 8'h00, 1'b0, 32'h0, 12'hFFF);
    push_req(CMD_READ_ALT, 8'h00, 1'b0, 32'h0, 12'd1);
    // Sequence zero is never newer
    push_req(CMD_PAYLOAD, 8'h01, 1'b1, 32'd0, 12'd0);
    // Embedded run then a form 7 run, then an out-of-bounds header and ignored bytes
    mb = {};
    add_run(mb, EMBEDDED, 24'd2, 8'd1);
    add_run(mb, 7, 24'd1, 8'd2);
    add_run(mb, 4, 24'hFFFF, 8'd0);
    foreach (mb[i]) push_req(CMD_PAYLOAD, mb[i], 1'b0, 32'd10, 12'd0);
    push_req(CMD_PAYLOAD, 8'hAA, 1'b0, 32'd10, 12'd0);
    push_req(CMD_PAYLOAD, 8'h55, 1'b1, 32'd10, 12'd0);
    // Same sequence again is obsolete
    push_req(CMD_PAYLOAD, 8'h03, 1'b1, 32'd10, 12'd0);
    // Truncated run
    push_req(CMD_PAYLOAD, 8'h00, 1'b0, 32'd11, 12'd0);
    push_req(CMD_PAYLOAD, 8'h23, 1'b0, 32'd11, 12'd0);
    push_req(CMD_PAYLOAD, 8'h77, 1'b1, 32'd11, 12'd0);
    push_req(CMD_READ_CLR, 8'h00, 1'b0, 32'h0, 12'd2);
    push_req(CMD_READ, 8'h00, 1'b0, 32'h0, 12'd2);
    push_req(CMD_READ, 8'h00, 1'b0, 32'h0, 12'd6);
    // Hold the sender until every reply is back
    wait_drained();

    // Random phases with different idling
    seq = 32'd11;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      pushed = pending_q.size();
      while (pending_q.size() - pushed < 250) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          seq = seq + 32'($urandom_range(1000, 1));
          push_mutation(seq, $urandom_range(4, 1), $urandom_range(9) == 0,
                        ph == 1 && pending_q.size() - pushed == 0);
        end else if (pick < 95) begin
          push_mutation(32'($urandom_range(seq)), $urandom_range(2, 1), 1'b0, 1'b0);
        end else begin
          push_read();
        end
      end
      // Let the phase run out under its own idling
      wait_drained();
    end
    // Largest sequence number: later mutations are all obsolete
    push_mutation(32'hFFFFFFFF, 2, 1'b0, 1'b0);
    push_mutation(32'hFFFFFFFF, 1, 1'b0, 1'b0);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && reply_q.size() == 0) begin
      $display("tb_block_delta_patch_decoder_top passed");
    end else begin
      $display("tb_block_delta_patch_decoder_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bdpd_pkg.sv
rtl/bdpd_ram.sv
rtl/bdpd_parser.sv
rtl/block_delta_patch_decoder_top.sv
tb/tb_block_delta_patch_decoder_top.sv
